>>> sv/u16ks_pkg.sv
// Shared types and constants for the UTF-16 keystroke sequencer.
package u16ks_pkg;

    localparam logic [7:0] KEY_CTRL_L    = 8'd29;
    localparam logic [7:0] KEY_SHIFT_L   = 8'd42;
    localparam logic [7:0] KEY_U         = 8'd22;
    localparam logic [7:0] KEY_SPC       = 8'd57;

    localparam logic [2:0] DIGITS_BMP    = 3'd4;
    localparam logic [2:0] DIGITS_MID    = 3'd5;
    localparam logic [2:0] DIGITS_TOP    = 3'd6;

    // Fixed part of a run: Ctrl, Shift, U presses and their releases.
    localparam logic [4:0] PREFIX_KEYS   = 5'd6;

    typedef struct packed {
        logic        error;
        logic [2:0]  digits;
        logic [23:0] nibbles;   // left-aligned, first digit in the top nibble
    } job_t;

    function automatic logic [7:0] hex_key(input logic [3:0] nib);
        logic [7:0] k;
        unique case (nib)
            4'h0: k = 8'd11;
            4'h1: k = 8'd2;
            4'h2: k = 8'd3;
            4'h3: k = 8'd4;
            4'h4: k = 8'd5;
            4'h5: k = 8'd6;
            4'h6: k = 8'd7;
            4'h7: k = 8'd8;
            4'h8: k = 8'd9;
            4'h9: k = 8'd10;
            4'ha: k = 8'd30;
            4'hb: k = 8'd48;
            4'hc: k = 8'd46;
            4'hd: k = 8'd32;
            4'he: k = 8'd18;
            default: k = 8'd33;
        endcase
        return k;
    endfunction

endpackage

>>> sv/u16ks_front.sv
// Front end: surrogate pairing, code point checks and digit alignment.
module u16ks_front
    import u16ks_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        unit_valid,
    output logic        unit_ready,
    input  logic [15:0] utf16_unit,
    output logic        job_valid,
    input  logic        job_ready,
    output job_t        job
);

    logic        pend_valid_reg, pend_valid_next;
    logic [9:0]  pend_bits_reg, pend_bits_next;
    logic        is_high, is_low, accept;
    logic [20:0] cp;

    assign is_high    = (utf16_unit[15:10] == 6'b110110);
    assign is_low     = (utf16_unit[15:10] == 6'b110111);
    assign unit_ready = job_ready;
    assign accept     = unit_valid && unit_ready;
    assign job_valid  = unit_valid && !is_high;

    always_comb
    begin
        if (is_low)
        begin
            cp = 21'h10000 + {1'b0, pend_bits_reg, utf16_unit[9:0]};
        end
        else
        begin
            cp = {5'd0, utf16_unit};
        end

        job.error = (is_low && !pend_valid_reg) || (!is_low && utf16_unit == 16'd0);

        if (cp[20:16] == 5'd0)
        begin
            job.digits  = DIGITS_BMP;
            job.nibbles = {cp[15:0], 8'd0};
        end
        else if (!cp[20])
        begin
            job.digits  = DIGITS_MID;
            job.nibbles = {cp[19:0], 4'd0};
        end
        else
        begin
            job.digits  = DIGITS_TOP;
            job.nibbles = {3'd0, cp};
        end
    end

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_bits_next  = pend_bits_reg;
        if (accept)
        begin
            pend_valid_next = is_high;
            if (is_high)
            begin
                pend_bits_next = utf16_unit[9:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_bits_reg <= pend_bits_next;
    end

endmodule

>>> sv/u16ks_fifo.sv
// Small job queue between front end and sequencer.
module u16ks_fifo
    import u16ks_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_job,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_job
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    job_t          mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

>>> sv/u16ks_back.sv
// Sequencer: expands a job to key/sync events, one per unstalled cycle.
module u16ks_back
    import u16ks_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       job_valid,
    output logic       job_ready,
    input  job_t       job,
    output logic       event_valid,
    input  logic       event_ready,
    output logic       is_sync,
    output logic [7:0] key_id,
    output logic       pressed,
    output logic       error,
    output logic       last
);

    logic        busy_reg, busy_next;
    logic        ev_valid_reg, ev_valid_next;
    logic [5:0]  step_reg, step_next;
    logic        err_reg, err_next;
    logic [2:0]  digs_reg, digs_next;
    logic [23:0] nib_reg, nib_next;
    logic        sync_reg, sync_next;
    logic [7:0]  key_reg, key_next;
    logic        press_reg, press_next;
    logic        error_reg, error_next;
    logic        last_reg, last_next;

    logic        adv, pop, cur_sync, cur_last, in_digits;
    logic [4:0]  k, digit_end, end_k;
    logic [7:0]  cur_key;
    logic        cur_press;

    assign job_ready   = !busy_reg;
    assign pop         = job_valid && !busy_reg;
    assign adv         = busy_reg && (!ev_valid_reg || event_ready);

    assign k           = step_reg[5:1];
    assign cur_sync    = step_reg[0];
    assign digit_end   = PREFIX_KEYS + {1'b0, digs_reg, 1'b0};
    assign end_k       = digit_end + 5'd1;
    assign in_digits   = (k >= PREFIX_KEYS) && (k < digit_end);
    assign cur_last    = err_reg || (cur_sync && k == end_k);

    always_comb
    begin
        cur_key   = KEY_SPC;
        cur_press = (k == digit_end);
        if (k < PREFIX_KEYS)
        begin
            unique case (k[2:0])
                3'd0, 3'd5: cur_key = KEY_CTRL_L;
                3'd1, 3'd4: cur_key = KEY_SHIFT_L;
                default:    cur_key = KEY_U;
            endcase
            cur_press = (k < 5'd3);
        end
        else if (in_digits)
        begin
            cur_key   = hex_key(nib_reg[23:20]);
            cur_press = !k[0];
        end
    end

    always_comb
    begin
        busy_next     = busy_reg;
        ev_valid_next = ev_valid_reg;
        step_next     = step_reg;
        err_next      = err_reg;
        digs_next     = digs_reg;
        nib_next      = nib_reg;
        sync_next     = sync_reg;
        key_next      = key_reg;
        press_next    = press_reg;
        error_next    = error_reg;
        last_next     = last_reg;

        if (pop)
        begin
            busy_next = 1'b1;
            step_next = '0;
            err_next  = job.error;
            digs_next = job.digits;
            nib_next  = job.nibbles;
        end

        if (adv)
        begin
            ev_valid_next = 1'b1;
            last_next     = cur_last;
            if (err_reg)
            begin
                sync_next  = 1'b0;
                key_next   = 8'd0;
                press_next = 1'b0;
                error_next = 1'b1;
            end
            else
            begin
                sync_next  = cur_sync;
                key_next   = cur_sync ? 8'd0 : cur_key;
                press_next = cur_sync ? 1'b0 : cur_press;
                error_next = 1'b0;
            end
            if (cur_last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                step_next = step_reg + 6'd1;
            end
            // move to the next digit after its release has been reported
            if (cur_sync && in_digits && k[0])
            begin
                nib_next = {nib_reg[19:0], 4'd0};
            end
        end
        else if (event_ready)
        begin
            ev_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            ev_valid_reg <= 1'b0;
            step_reg     <= '0;
        end
        else
        begin
            busy_reg     <= busy_next;
            ev_valid_reg <= ev_valid_next;
            step_reg     <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg   <= err_next;
        digs_reg  <= digs_next;
        nib_reg   <= nib_next;
        sync_reg  <= sync_next;
        key_reg   <= key_next;
        press_reg <= press_next;
        error_reg <= error_next;
        last_reg  <= last_next;
    end

    assign event_valid = ev_valid_reg;
    assign is_sync     = sync_reg;
    assign key_id      = key_reg;
    assign pressed     = press_reg;
    assign error       = error_reg;
    assign last        = last_reg;

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> step_reg < 6'd40)
        else $error("step counter beyond longest run");

    a_error_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (ev_valid_reg && error_reg) |-> (last_reg && !sync_reg && key_reg == 8'd0))
        else $error("error transaction not a lone final item");

    a_sync_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (ev_valid_reg && sync_reg) |-> (key_reg == 8'd0 && !press_reg))
        else $error("sync transaction carries key data");

    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && !cur_last) |=> busy_reg)
        else $error("run ended early");

endmodule

>>> sv/utf16_unicode_keystroke_sequencer.sv
// Top level of the UTF-16 to Ctrl+Shift+U keystroke sequencer.
//
// Input channel: utf16_unit with unit_valid / unit_ready, one code unit per
// transaction. Output channel: is_sync, key_id, pressed, error, last with
// event_valid / event_ready, one key or sync event per transaction.
// A high surrogate is held and yields nothing; a lone low surrogate or a zero
// unit yields a single error transaction. Any other unit yields a run of
// 12 + 4 * digits + 4 transactions (32, 36 or 40) ending with last set.
// The front end classifies a unit in the cycle it is taken and writes a job
// into a QUEUE_DEPTH-entry queue; the sequencer emits one event per cycle
// into an output register while event_ready is high, so a unit's job is held
// in the queue entry, then in the sequencer state, then in the output register.
// Throughput is set by the sequencer, which takes a new job only after its run ends.
// The input side keeps accepting while the queue has room.
// When event_ready is low while an event is waiting, the output register holds and the sequencer waits.
// Reset clears the held surrogate, the queue and the sequencer.
module utf16_unicode_keystroke_sequencer
    import u16ks_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        unit_valid,
    output logic        unit_ready,
    input  logic [15:0] utf16_unit,
    output logic        event_valid,
    input  logic        event_ready,
    output logic        is_sync,
    output logic [7:0]  key_id,
    output logic        pressed,
    output logic        error,
    output logic        last
);

    logic f_valid, f_ready;
    job_t f_job;
    logic q_valid, q_ready;
    job_t q_job;

    u16ks_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .unit_valid (unit_valid),
        .unit_ready (unit_ready),
        .utf16_unit (utf16_unit),
        .job_valid  (f_valid),
        .job_ready  (f_ready),
        .job        (f_job)
    );

    u16ks_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_job   (f_job),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_job    (q_job)
    );

    u16ks_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (q_valid),
        .job_ready   (q_ready),
        .job         (q_job),
        .event_valid (event_valid),
        .event_ready (event_ready),
        .is_sync     (is_sync),
        .key_id      (key_id),
        .pressed     (pressed),
        .error       (error),
        .last        (last)
    );

endmodule

>>> test/testbench.sv
// Testbench for the UTF-16 to Ctrl+Shift+U keystroke sequencer.
module testbench
    import u16ks_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [15:0] HIGH_FIRST = 16'hD800;
    localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
    localparam logic [15:0] LOW_FIRST  = 16'hDC00;
    localparam logic [15:0] LOW_LAST   = 16'hDFFF;
    localparam int          UNIT_COUNT = 235;

    localparam logic [7:0] DIGIT_KEYS [16] = '{
        8'd11, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8,
        8'd9, 8'd10, 8'd30, 8'd48, 8'd46, 8'd32, 8'd18, 8'd33
    };

    typedef struct packed {
        logic       is_sync;
        logic [7:0] key_id;
        logic       pressed;
        logic       error;
        logic       last;
    } key_event_t;

    typedef struct packed {
        logic        drain;
        logic [15:0] unit;
    } pending_unit_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        unit_valid = 1'b0;
    logic        unit_ready;
    logic [15:0] utf16_unit = '0;
    logic        event_valid;
    logic        event_ready = 1'b0;
    logic        is_sync;
    logic [7:0]  key_id;
    logic        pressed;
    logic        error;
    logic        last;

    pending_unit_t pending_units[$];
    key_event_t    expected_events[$];
    logic [15:0]   held_high = '0;
    int            units_taken = 0;
    int            event_mismatches = 0;
    int            burst_left = 0;
    int            gap_left = 0;
    int            ready_mode = 0;
    int            mode_left = 0;

    utf16_unicode_keystroke_sequencer i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .unit_valid  (unit_valid),
        .unit_ready  (unit_ready),
        .utf16_unit  (utf16_unit),
        .event_valid (event_valid),
        .event_ready (event_ready),
        .is_sync     (is_sync),
        .key_id      (key_id),
        .pressed     (pressed),
        .error       (error),
        .last        (last)
    );

    always #2 clk = ~clk;

    function automatic void push_key(input logic [7:0] key, input logic down,
                                     input logic final_one);
        expected_events.push_back('{1'b0, key, down, 1'b0, 1'b0});
        expected_events.push_back('{1'b1, 8'd0, 1'b0, 1'b0, final_one});
    endfunction

    function automatic void predict_keystrokes(input logic [15:0] unit);
        logic [20:0] code_point;
        int          digits;
        int          i;
        logic [3:0]  nib;
        if (unit >= HIGH_FIRST && unit <= HIGH_LAST)
        begin
            held_high = unit;
            return;
        end
        if (unit >= LOW_FIRST && unit <= LOW_LAST)
        begin
            if (held_high >= HIGH_FIRST && held_high <= HIGH_LAST)
                code_point = 21'h10000 + {1'b0, held_high[9:0], unit[9:0]};
            else
                code_point = '0;
        end
        else
        begin
            code_point = {5'd0, unit};
        end
        held_high = '0;
        if (code_point == '0)
        begin
            expected_events.push_back('{1'b0, 8'd0, 1'b0, 1'b1, 1'b1});
            return;
        end
        digits = (code_point > 21'hFFFFF) ? 6 : (code_point > 21'hFFFF) ? 5 : 4;
        push_key(KEY_CTRL_L, 1'b1, 1'b0);
        push_key(KEY_SHIFT_L, 1'b1, 1'b0);
        push_key(KEY_U, 1'b1, 1'b0);
        push_key(KEY_U, 1'b0, 1'b0);
        push_key(KEY_SHIFT_L, 1'b0, 1'b0);
        push_key(KEY_CTRL_L, 1'b0, 1'b0);
        for (i = digits - 1; i >= 0; i--)
        begin
            nib = code_point[4 * i +: 4];
            push_key(DIGIT_KEYS[nib], 1'b1, 1'b0);
            push_key(DIGIT_KEYS[nib], 1'b0, 1'b0);
        end
        push_key(KEY_SPC, 1'b1, 1'b0);
        push_key(KEY_SPC, 1'b0, 1'b1);
    endfunction

    function automatic void add_unit(input logic [15:0] unit, input logic drain = 1'b0);
        pending_units.push_back('{drain, unit});
    endfunction

    // Driver: bursts with random gaps; a drain-marked unit waits for all events.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_valid <= 1'b0;
            utf16_unit <= '0;
        end
        else
        begin
            if (unit_valid && unit_ready)
            begin
                predict_keystrokes(utf16_unit);
                units_taken <= units_taken + 1;
            end
            if (!unit_valid || unit_ready)
            begin
                if (gap_left != 0)
                begin
                    unit_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (pending_units.size() == 0 ||
                         (pending_units[0].drain && expected_events.size() != 0))
                begin
                    unit_valid <= 1'b0;
                end
                else
                begin
                    unit_valid <= 1'b1;
                    utf16_unit <= pending_units[0].unit;
                    void'(pending_units.pop_front());
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
        end
    end

    // Monitor: receiver stalls in modes of its own, each transaction checked.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        key_event_t seen;
        key_event_t want;
        if (!rst_n)
        begin
            event_ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                ready_mode <= $urandom_range(0, 2);
                mode_left <= $urandom_range(20, 200);
            end
            else
            begin
                mode_left <= mode_left - 1;
            end
            case (ready_mode)
                0: event_ready <= 1'b1;
                1: event_ready <= ($urandom_range(0, 3) != 0);
                default: event_ready <= ($urandom_range(0, 7) == 0);
            endcase
            if (event_valid && event_ready)
            begin
                seen = '{is_sync, key_id, pressed, error, last};
                if (expected_events.size() == 0)
                begin
                    if (event_mismatches < 10)
                        $display("%0t: unexpected sync=%0b key=%0d press=%0b err=%0b last=%0b",
                                 $realtime, seen.is_sync, seen.key_id, seen.pressed,
                                 seen.error, seen.last);
                    event_mismatches++;
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (seen.is_sync !== want.is_sync || seen.key_id !== want.key_id ||
                        seen.pressed !== want.pressed || seen.error !== want.error ||
                        seen.last !== want.last)
                    begin
                        if (event_mismatches < 10)
                        begin
                            $write("%0t: want sync=%0b key=%0d press=%0b err=%0b last=%0b;",
                                   $realtime, want.is_sync, want.key_id, want.pressed,
                                   want.error, want.last);
                            $display(" got sync=%0b key=%0d press=%0b err=%0b last=%0b",
                                     seen.is_sync, seen.key_id, seen.pressed,
                                     seen.error, seen.last);
                        end
                        event_mismatches++;
                    end
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin : stimulus
        logic [15:0] u;
        int          total_units;

        // BMP extremes and every hex digit
        add_unit(16'h0001);
        add_unit(16'hFFFF);
        add_unit(16'h1234);
        add_unit(16'h5678);
        add_unit(16'h89EF);
        add_unit(16'hABCD);
        add_unit(16'hD7FF);
        add_unit(16'hE000);
        // zero unit and lone low surrogates
        add_unit(16'h0000);
        add_unit(16'hDC00);
        add_unit(16'hDFFF, 1'b1);
        // surrogate pairs: lowest, highest, five/six digit boundary
        add_unit(16'hD800);
        add_unit(16'hDC00);
        add_unit(16'hDBFF);
        add_unit(16'hDFFF);
        add_unit(16'hDBBF);
        add_unit(16'hDFFF);
        add_unit(16'hDBC0);
        add_unit(16'hDC00);
        // high replaced by a later high, then a high dropped by a plain unit
        add_unit(16'hD800);
        add_unit(16'hDBFF);
        add_unit(16'hDC00);
        add_unit(16'hD801);
        add_unit(16'h0061);
        // high then zero, then the low that follows is lone
        add_unit(16'hD900);
        add_unit(16'h0000);
        add_unit(16'hDC01);

        while (pending_units.size() < UNIT_COUNT)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4:
                begin
                    add_unit(HIGH_FIRST + 16'($urandom_range(0, 1023)),
                             $urandom_range(0, 29) == 0);
                    add_unit(LOW_FIRST + 16'($urandom_range(0, 1023)));
                end
                5, 6:
                begin
                    u = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(1, 16'hD7FF))
                                                    : 16'($urandom_range(16'hE000, 16'hFFFF));
                    add_unit(u, $urandom_range(0, 29) == 0);
                end
                7:
                begin
                    add_unit(LOW_FIRST + 16'($urandom_range(0, 1023)));
                end
                8:
                begin
                    add_unit(HIGH_FIRST + 16'($urandom_range(0, 1023)));
                    u = 16'($urandom);
                    add_unit(u);
                end
                default:
                begin
                    case ($urandom_range(0, 3))
                        0: add_unit(16'h0000);
                        1: add_unit(16'hFFFF);
                        2: add_unit(HIGH_FIRST + 16'($urandom_range(0, 1023)));
                        default: add_unit(16'($urandom_range(1, 255)));
                    endcase
                end
            endcase
        end
        total_units = pending_units.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (units_taken != total_units || expected_events.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        if (event_mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> filelist.f
sv/u16ks_pkg.sv
sv/u16ks_front.sv
sv/u16ks_fifo.sv
sv/u16ks_back.sv
sv/utf16_unicode_keystroke_sequencer.sv
test/testbench.sv
